@@ src/bsdel_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsdel_pkg: shared types and codes
// Operation and status codes, field widths and the per-cell control group
// of the bounded stack with delete-at.
// ----------------------------------------------------------------------------
package bsdel_pkg;

	// Fixed field widths of the stream items
	localparam int OPCODE_W = 2;
	localparam int VALUE_W  = 16;
	localparam int POS_W    = 7;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 8;
	localparam int CAP_W    = 8;

	localparam logic [CAP_W-1:0] CAP_RESET = 8'd3;

	// Operation codes
	localparam logic [OPCODE_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_POP  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_DEL  = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	// Broadcast to every cell for the item being taken this cycle
	typedef struct packed {
		logic push_ok;
		logic pop_ok;
		logic del_ok;
	} cell_ctrl_t;

endpackage

@@ src/bsdel_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsdel_cell: one stack slot
// Holds one entry. Loads the pushed value when it is the next free slot,
// takes its upper neighbour's entry when a delete-at closes the gap, and
// drives its entry onto the read bus when it is the slot being removed.
// ----------------------------------------------------------------------------
module bsdel_cell #(
	parameter int ENTRY_WIDTH = 16,
	parameter int CNT_W       = 8,
	parameter int INDEX       = 0
) (
	input  logic                   clk,
	input  bsdel_pkg::cell_ctrl_t  ctrl,
	input  logic [CNT_W-1:0]       cnt,
	input  logic [CNT_W-1:0]       pos,
	input  logic [ENTRY_WIDTH-1:0] wr_value,
	input  logic [ENTRY_WIDTH-1:0] next_data,
	output logic [ENTRY_WIDTH-1:0] data,
	output logic [ENTRY_WIDTH-1:0] rd_data
);

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic [ENTRY_WIDTH-1:0] entry_q;
	logic                   load_push;
	logic                   load_shift;
	logic                   sel;

	assign load_push  = ctrl.push_ok && (cnt == IDX);
	// slots from the deleted one up to the one below the top move down
	assign load_shift = ctrl.del_ok && (IDX >= pos) && ((IDX + CNT_W'(1)) < cnt);
	assign sel        = (ctrl.pop_ok && ((IDX + CNT_W'(1)) == cnt)) ||
	                    (ctrl.del_ok && (IDX == pos));

	always_ff @(posedge clk) begin
		if (load_push) begin
			entry_q <= wr_value;
		end else if (load_shift) begin
			entry_q <= next_data;
		end
	end

	assign data    = entry_q;
	assign rd_data = sel ? entry_q : '0;

endmodule

@@ src/bounded_stack_with_delete_at.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_stack_with_delete_at: LIFO stack with push, pop and delete-at
// Row of slot cells with a shared fill count and a registered result.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one operation per item: push, pop, or delete the entry
//   at a position counted from the bottom. Unknown opcodes do nothing.
//   m_* channel returns one result per item: removed data, status, count
//   and the empty and full flags after the operation.
//   cfg_* channel writes the capacity; always ready. Write it while idle.
//   Capacity 0 acts as 1, values above MAX_DEPTH act as MAX_DEPTH.
// Timing:
//   One item per cycle while s_tready is high. The whole operation, including the
//   shift of every slot above a deleted entry, happens in the cycle the item is
//   taken; the result is captured in the output register at the end of that cycle.
//   The result register holds while m_tready is low and s_tready drops only
//   when it is full and not being drained, so back-to-back items flow.
// Reset:
//   Stack empty, capacity 3, no result pending. Slot contents are not
//   cleared; only slots below the fill count are ever read.
// ----------------------------------------------------------------------------
module bounded_stack_with_delete_at #(
	parameter int MAX_DEPTH   = 128,
	parameter int ENTRY_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // push_value[15:0], position[22:16], zero pad
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // data_out[15:0], status[17:16], count[25:18],
	                              // is_empty[26], is_full[27], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data  // capacity
);

	localparam int CNT_W = $clog2(MAX_DEPTH + 1);
	localparam int WW    = (CNT_W > bsdel_pkg::CAP_W) ? CNT_W : bsdel_pkg::CAP_W;
	localparam logic [WW-1:0] DEPTH_W = WW'(MAX_DEPTH);

	logic [bsdel_pkg::OPCODE_W-1:0] opcode;
	logic [bsdel_pkg::VALUE_W-1:0]  push_value;
	logic [bsdel_pkg::POS_W-1:0]    position;

	logic [CNT_W-1:0]            cnt_q;
	logic [bsdel_pkg::CAP_W-1:0] cap_q;
	logic                        m_tvalid_q;
	logic [31:0]                 m_tdata_q;

	logic                        s_accept;
	logic [WW-1:0]               eff_cap;
	logic [WW-1:0]               cnt_w;
	bsdel_pkg::cell_ctrl_t       ctrl;
	logic [bsdel_pkg::STATUS_W-1:0] status;
	logic [CNT_W-1:0]            cnt_nxt;
	logic [CNT_W-1:0]            pos_c;
	logic [ENTRY_WIDTH-1:0]      wr_value;
	logic [ENTRY_WIDTH-1:0]      rd_any;
	logic [ENTRY_WIDTH-1:0]      cell_data [MAX_DEPTH];
	logic [ENTRY_WIDTH-1:0]      cell_rd   [MAX_DEPTH];
	logic [bsdel_pkg::VALUE_W-1:0] data_out;

	assign opcode     = s_tuser;
	assign push_value = s_tdata[15:0];
	assign position   = s_tdata[22:16];

	assign s_tready  = !m_tvalid_q || m_tready;
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// clamp the capacity register to 1..MAX_DEPTH
	always_comb begin
		eff_cap = WW'(cap_q);
		if (eff_cap == '0) begin
			eff_cap = WW'(1);
		end
		if (eff_cap > DEPTH_W) begin
			eff_cap = DEPTH_W;
		end
	end

	assign cnt_w    = WW'(cnt_q);
	assign pos_c    = CNT_W'(position);
	assign wr_value = ENTRY_WIDTH'(push_value);

	always_comb begin
		ctrl    = '0;
		status  = bsdel_pkg::ST_OK;
		cnt_nxt = cnt_q;
		unique case (opcode)
			bsdel_pkg::OP_PUSH: begin
				if (cnt_w >= eff_cap) begin
					status = bsdel_pkg::ST_FULL;
				end else begin
					ctrl.push_ok = s_accept;
					cnt_nxt      = cnt_q + CNT_W'(1);
				end
			end
			bsdel_pkg::OP_POP: begin
				if (cnt_q == '0) begin
					status = bsdel_pkg::ST_EMPTY;
				end else begin
					ctrl.pop_ok = s_accept;
					cnt_nxt     = cnt_q - CNT_W'(1);
				end
			end
			bsdel_pkg::OP_DEL: begin
				// compare at full width so a large position never wraps
				if (WW'(position) >= cnt_w) begin
					status = bsdel_pkg::ST_RANGE;
				end else begin
					ctrl.del_ok = s_accept;
					cnt_nxt     = cnt_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
		logic [ENTRY_WIDTH-1:0] next_data;
		if (i == MAX_DEPTH - 1) begin : g_top
			assign next_data = '0;
		end else begin : g_mid
			assign next_data = cell_data[i+1];
		end

		bsdel_cell #(
			.ENTRY_WIDTH (ENTRY_WIDTH),
			.CNT_W       (CNT_W),
			.INDEX       (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.cnt       (cnt_q),
			.pos       (pos_c),
			.wr_value  (wr_value),
			.next_data (next_data),
			.data      (cell_data[i]),
			.rd_data   (cell_rd[i])
		);
	end

	// at most one cell drives the read bus
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			rd_any = rd_any | cell_rd[i];
		end
	end

	assign data_out = bsdel_pkg::VALUE_W'(rd_any);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			cap_q      <= bsdel_pkg::CAP_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (s_accept) begin
				cnt_q      <= cnt_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result payload: hold while stalled
	always_ff @(posedge clk) begin
		if (s_accept) begin
			m_tdata_q <= {4'd0,
			              (WW'(cnt_nxt) >= eff_cap),
			              (cnt_nxt == '0),
			              bsdel_pkg::COUNT_W'(cnt_nxt),
			              status,
			              data_out};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(cnt_q) <= DEPTH_W)
		else $error("fill count above build depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push_ok |=> (cnt_q == $past(cnt_q) + CNT_W'(1)) && m_tvalid)
		else $error("accepted push did not grow the stack");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.pop_ok || ctrl.del_ok) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("accepted removal did not shrink the stack");

	a_one_remove: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl.push_ok, ctrl.pop_ok, ctrl.del_ok}))
		else $error("more than one stack operation in a cycle");

endmodule

@@ sim/tb_bounded_stack_with_delete_at.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_stack_with_delete_at: self-checking bench for the stack block
// Drives push, pop, delete-at and unused-opcode items with random gaps and output stalls,
// predicts each result from a shadow copy of the stack and compares every
// field of every returned item in order.
// ----------------------------------------------------------------------------
module tb_bounded_stack_with_delete_at;

	localparam int STACK_DEPTH = 128;
	localparam int ENTRY_W     = 16;
	localparam logic [bsdel_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [bsdel_pkg::VALUE_W-1:0]  data;
		logic [bsdel_pkg::STATUS_W-1:0] status;
		logic [bsdel_pkg::COUNT_W-1:0]  count;
		logic                           is_empty;
		logic                           is_full;
	} stack_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // push_value[15:0], position[22:16], zero pad
	logic [1:0]  s_tuser;   // opcode[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // data_out[15:0], status[17:16], count[25:18],
	                        // is_empty[26], is_full[27], zero pad
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;  // capacity

	// Shadow stack
	logic [bsdel_pkg::VALUE_W-1:0] shadow_stack [STACK_DEPTH];
	int                            shadow_fill;
	logic [bsdel_pkg::CAP_W-1:0]   shadow_cap;

	stack_result_t pending_results [$];

	int error_count;
	int items_sent;
	int results_checked;
	int cap_writes;
	int stall_cycles;
	int status_seen [4];
	int burst_left;
	bit gaps_on;
	int hold_off_cycles;
	int rx_run_left;
	bit rx_ready_run;

	bounded_stack_with_delete_at #(
		.MAX_DEPTH   (STACK_DEPTH),
		.ENTRY_WIDTH (ENTRY_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("FAILURE");
		$finish;
	end

	function automatic int active_capacity(input logic [bsdel_pkg::CAP_W-1:0] cap);
		if (cap == 0)
			return 1;
		if (int'(cap) > STACK_DEPTH)
			return STACK_DEPTH;
		return int'(cap);
	endfunction

	// Apply one operation to the shadow stack and return the result it gives
	function automatic stack_result_t apply_stack_op(input logic [bsdel_pkg::OPCODE_W-1:0] op,
			input logic [bsdel_pkg::VALUE_W-1:0] value,
			input logic [bsdel_pkg::POS_W-1:0] pos);
		stack_result_t r;
		int            cap;
		int            i;
		cap = active_capacity(shadow_cap);
		r = '0;
		r.status = bsdel_pkg::ST_OK;
		case (op)
			bsdel_pkg::OP_PUSH: begin
				if (shadow_fill >= cap) begin
					r.status = bsdel_pkg::ST_FULL;
				end else begin
					shadow_stack[shadow_fill] = value;
					shadow_fill++;
				end
			end
			bsdel_pkg::OP_POP: begin
				if (shadow_fill == 0) begin
					r.status = bsdel_pkg::ST_EMPTY;
				end else begin
					shadow_fill--;
					r.data = shadow_stack[shadow_fill];
				end
			end
			bsdel_pkg::OP_DEL: begin
				if (int'(pos) >= shadow_fill) begin
					r.status = bsdel_pkg::ST_RANGE;
				end else begin
					r.data = shadow_stack[pos];
					for (i = int'(pos); i + 1 < shadow_fill; i++)
						shadow_stack[i] = shadow_stack[i + 1];
					shadow_fill--;
				end
			end
			default: begin
			end
		endcase
		r.count    = shadow_fill[bsdel_pkg::COUNT_W-1:0];
		r.is_empty = (shadow_fill == 0);
		r.is_full  = (shadow_fill >= cap);
		return r;
	endfunction

	// Offer one item and hold it until taken
	task automatic send_item(input logic [bsdel_pkg::OPCODE_W-1:0] op,
			input logic [bsdel_pkg::VALUE_W-1:0] value,
			input logic [bsdel_pkg::POS_W-1:0] pos);
		@(negedge clk);
		if (gaps_on && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, pos, value};
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
			stall_cycles++;
		end
		items_sent++;
		pending_results.push_back(apply_stack_op(op, value, pos));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [bsdel_pkg::CAP_W-1:0] cap);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do
			@(posedge clk);
		while (!cfg_ready);
		shadow_cap = cap;
		cap_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [bsdel_pkg::OPCODE_W-1:0] pick_opcode(input int push_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			return OP_UNUSED;
		if (roll < push_pct)
			return bsdel_pkg::OP_PUSH;
		if (roll < push_pct + (100 - push_pct) / 2)
			return bsdel_pkg::OP_POP;
		return bsdel_pkg::OP_DEL;
	endfunction

	// Mostly in-range positions, some anywhere in the field
	function automatic logic [bsdel_pkg::POS_W-1:0] pick_position();
		if (shadow_fill > 0 && $urandom_range(0, 9) < 8)
			return bsdel_pkg::POS_W'($urandom_range(0, shadow_fill - 1));
		return bsdel_pkg::POS_W'($urandom_range(0, 127));
	endfunction

	task automatic test_directed_ops();
		// reset capacity of three
		send_item(bsdel_pkg::OP_POP, 16'h0000, 7'd0);
		send_item(bsdel_pkg::OP_DEL, 16'h0000, 7'd0);
		send_item(bsdel_pkg::OP_DEL, 16'hFFFF, 7'd127);
		send_item(OP_UNUSED, 16'hFFFF, 7'd127);
		send_item(bsdel_pkg::OP_PUSH, 16'h0000, 7'd0);
		send_item(bsdel_pkg::OP_PUSH, 16'hFFFF, 7'd127);
		send_item(bsdel_pkg::OP_PUSH, 16'h8001, 7'd0);
		send_item(bsdel_pkg::OP_PUSH, 16'h1234, 7'd0);
		send_item(OP_UNUSED, 16'h0000, 7'd0);
		send_item(bsdel_pkg::OP_DEL, 16'h0000, 7'd3);
		send_item(bsdel_pkg::OP_DEL, 16'h0000, 7'd1);
		send_item(bsdel_pkg::OP_POP, 16'h0000, 7'd0);
		send_item(bsdel_pkg::OP_POP, 16'h0000, 7'd0);
		send_item(bsdel_pkg::OP_POP, 16'h0000, 7'd0);
		// zero capacity behaves as one
		write_capacity(8'd0);
		send_item(bsdel_pkg::OP_PUSH, 16'h5A5A, 7'd0);
		send_item(bsdel_pkg::OP_PUSH, 16'hA5A5, 7'd0);
		send_item(bsdel_pkg::OP_DEL, 16'h0000, 7'd0);
		send_item(bsdel_pkg::OP_PUSH, 16'h7FFF, 7'd0);
		send_item(bsdel_pkg::OP_POP, 16'h0000, 7'd0);
	endtask

	task automatic test_capacity_lowered();
		write_capacity(8'd128);
		repeat (10) send_item(bsdel_pkg::OP_PUSH, 16'($urandom), 7'd0);
		write_capacity(8'd4);
		send_item(bsdel_pkg::OP_PUSH, 16'($urandom), 7'd0);
		send_item(OP_UNUSED, 16'($urandom), 7'd0);
		send_item(bsdel_pkg::OP_DEL, 16'h0000, 7'd2);
		while (shadow_fill > 3)
			send_item(bsdel_pkg::OP_POP, 16'h0000, 7'd0);
		send_item(bsdel_pkg::OP_PUSH, 16'($urandom), 7'd0);
		send_item(bsdel_pkg::OP_PUSH, 16'($urandom), 7'd0);
		while (shadow_fill > 0)
			send_item(bsdel_pkg::OP_POP, 16'h0000, 7'd0);
	endtask

	// Fill to the build depth, hit both ends, then empty out
	task automatic test_deep_fill(input logic [bsdel_pkg::CAP_W-1:0] cap);
		write_capacity(cap);
		while (shadow_fill < STACK_DEPTH)
			send_item(bsdel_pkg::OP_PUSH, 16'($urandom), pick_position());
		send_item(bsdel_pkg::OP_PUSH, 16'($urandom), 7'd0);
		send_item(bsdel_pkg::OP_DEL, 16'h0000, 7'd127);
		send_item(bsdel_pkg::OP_PUSH, 16'($urandom), 7'd0);
		send_item(bsdel_pkg::OP_DEL, 16'h0000, 7'd0);
		while (shadow_fill > 0)
			send_item($urandom_range(0, 1) ? bsdel_pkg::OP_POP : bsdel_pkg::OP_DEL,
				16'($urandom), pick_position());
	endtask

	task automatic test_backpressure();
		wait_idle();
		gaps_on = 1'b0;
		@(posedge clk);
		hold_off_cycles = 200;
		repeat (60)
			send_item(pick_opcode(50), 16'($urandom), pick_position());
		gaps_on = 1'b1;
	endtask

	task automatic run_random_phase(input logic [bsdel_pkg::CAP_W-1:0] cap, input int n_items,
			input int push_pct);
		write_capacity(cap);
		repeat (n_items)
			send_item(pick_opcode(push_pct), 16'($urandom), pick_position());
	endtask

	task automatic test_random_mix();
		run_random_phase(8'd1, 150, 45);
		run_random_phase(8'd2, 150, 45);
		run_random_phase(8'($urandom_range(4, 20)), 200, 50);
		run_random_phase(8'd128, 200, 65);
		run_random_phase(8'($urandom_range(1, 128)), 150, 55);
		run_random_phase(8'd255, 150, 70);
		run_random_phase(8'd0, 100, 40);
		run_random_phase(8'($urandom_range(1, 128)), 150, 35);
	endtask

	task automatic report_mismatch(input string what, input stack_result_t want,
			input stack_result_t got);
		error_count++;
		if (error_count <= 10) begin
			$display("%0t mismatch (%s): expected data=%h status=%0d count=%0d empty=%b full=%b",
				$realtime, what, want.data, want.status, want.count, want.is_empty,
				want.is_full);
			$display("    got data=%h status=%0d count=%0d empty=%b full=%b",
				got.data, got.status, got.count, got.is_empty, got.is_full);
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		stack_result_t got;
		stack_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.data     = m_tdata[15:0];
			got.status   = m_tdata[17:16];
			got.count    = m_tdata[25:18];
			got.is_empty = m_tdata[26];
			got.is_full  = m_tdata[27];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected item", '0, got);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				status_seen[want.status]++;
				if (got.data !== want.data || got.status !== want.status ||
						got.count !== want.count || got.is_empty !== want.is_empty ||
						got.is_full !== want.is_full)
					report_mismatch("field", want, got);
			end
		end
	end

	// Output stalls: alternating ready and stall runs, plus long hold-offs on request
	initial begin
		m_tready = 1'b0;
		rx_run_left = 0;
		rx_ready_run = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				m_tready <= 1'b0;
				hold_off_cycles--;
			end else begin
				if (rx_run_left == 0) begin
					rx_ready_run = !rx_ready_run;
					if (rx_ready_run)
						rx_run_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 12);
					else
						rx_run_left = $urandom_range(1, 6);
				end
				rx_run_left--;
				m_tready <= rx_ready_run;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		shadow_fill = 0;
		shadow_cap  = bsdel_pkg::CAP_RESET;
		error_count = 0;
		items_sent = 0;
		results_checked = 0;
		cap_writes = 0;
		stall_cycles = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		hold_off_cycles = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_ops();
		test_capacity_lowered();
		test_deep_fill(8'd128);
		test_deep_fill(8'd255);
		test_backpressure();
		test_random_mix();

		wait_idle();
		repeat (5) @(posedge clk);
		$display("Run covered %0d items and %0d checked results over %0d capacity writes.",
			items_sent, results_checked, cap_writes);
		$display("Status ok/full/empty/range: %0d/%0d/%0d/%0d; input stalled %0d cycles.",
			status_seen[bsdel_pkg::ST_OK], status_seen[bsdel_pkg::ST_FULL],
			status_seen[bsdel_pkg::ST_EMPTY], status_seen[bsdel_pkg::ST_RANGE],
			stall_cycles);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
